>>> rtl/ttps_pkg.sv
// ----------------------------------------------------------------------------
// ttps_pkg: shared definitions for the transposition table probe store
// Field widths, operation and bound codes, the item and slot layouts and the
// mate score adjustment used by both the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package ttps_pkg;

  // Default number of table slots
  localparam int unsigned ENTRIES_DEF = 4096;

  // Field widths
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned PLY_W   = 8;
  localparam int unsigned SCORE_W = 24;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned MOVE_W  = 32;
  localparam int unsigned THR_W   = 23;

  // Stream and configuration port widths
  localparam int unsigned IN_TDATA_W  = 192;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned CFG_IDX_W   = 2;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Key bits folded into the slot index per cycle (non power of two tables)
  localparam int unsigned MOD_STEP = 4;

  // Operation codes
  localparam logic FUNC_PROBE = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  // Bound kinds
  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPPER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATE_THR = 2'd1;

  // Configuration register reset values
  localparam logic             ENABLE_RST   = 1'b1;
  localparam logic [THR_W-1:0] MATE_THR_RST = 23'd100000;

  // Score range limits, in the widened arithmetic of the mate adjustment
  localparam logic signed [26:0] SCORE_MAX_X = 27'sd8388607;
  localparam logic signed [26:0] SCORE_MIN_X = -27'sd8388608;

  // Back part states
  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EVAL
  } back_state_t;

  // Configuration as seen by the front and back parts
  typedef struct packed {
    logic             enable;
    logic [THR_W-1:0] mate_threshold;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic                      func;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        need_depth;
    logic [PLY_W-1:0]          ply;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
    logic signed [SCORE_W-1:0] score;
    logic [KIND_W-1:0]         kind;
    logic [MOVE_W-1:0]         move;
  } op_t;

  // One table slot
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
    logic [KIND_W-1:0]         kind;
    logic [DEPTH_W-1:0]        depth;
    logic [MOVE_W-1:0]         move;
  } slot_t;

  // One result item, last field in the lowest bits
  typedef struct packed {
    logic [MOVE_W-1:0]         move_out;
    logic                      key_hit;
    logic signed [SCORE_W-1:0] score_out;
    logic                      score_valid;
  } result_t;

  // Mate score adjustment. A score whose magnitude reaches the threshold has
  // its magnitude grown (store) or shrunk (probe) by the ply count, the old
  // sign reapplied (a shrink may cross zero), saturating to the score range.
  function automatic logic signed [SCORE_W-1:0] mate_adjust(
    input logic signed [SCORE_W-1:0] s,
    input logic [PLY_W-1:0]          ply,
    input logic [THR_W-1:0]          thr,
    input logic                      grow
  );
    logic signed [26:0] sx;
    logic signed [26:0] mag;
    logic signed [26:0] plyx;
    logic signed [26:0] m2;
    logic signed [26:0] r;
    logic signed [SCORE_W-1:0] res;
    sx   = {{3{s[SCORE_W-1]}}, s};
    mag  = s[SCORE_W-1] ? -sx : sx;
    plyx = $signed({19'd0, ply});
    m2   = grow ? mag + plyx : mag - plyx;
    r    = s[SCORE_W-1] ? -m2 : m2;
    if (mag < $signed({4'd0, thr})) begin
      res = s;
    end else if (r > SCORE_MAX_X) begin
      res = SCORE_MAX_X[SCORE_W-1:0];
    end else if (r < SCORE_MIN_X) begin
      res = SCORE_MIN_X[SCORE_W-1:0];
    end else begin
      res = r[SCORE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ttps_ram.sv
// ----------------------------------------------------------------------------
// ttps_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ttps_fifo.sv
// ----------------------------------------------------------------------------
// ttps_fifo: short item queue between the front and back parts
// A small register queue with a count; the head is read from registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = ttps_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             full,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data,
  output      logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/ttps_front.sv
// ----------------------------------------------------------------------------
// ttps_front: item intake and classification
// Holds each accepted item, works out its slot index (key modulo the entry
// count) and the stored form of a store's score, then queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_front #(
  parameter int unsigned ENTRIES = ttps_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W  = $clog2(ENTRIES),
  localparam int unsigned QW     = $bits(ttps_pkg::op_t) + IDX_W
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire ttps_pkg::op_t       in_op,
  input  wire ttps_pkg::cfg_t      cfg,
  input  wire logic                clear_done,
  output      logic                q_push,
  output      logic [QW-1:0]       q_data,
  input  wire logic                q_full
);

  localparam bit POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

  ttps_pkg::op_t    hold_op_r;
  logic             hold_valid_r;
  logic             idx_ready;
  logic [IDX_W-1:0] idx;
  logic             accept;
  ttps_pkg::op_t    q_op;

  // Handshake: a held item goes once its index is known and the queue has room
  assign q_push   = hold_valid_r && idx_ready && !q_full;
  assign in_ready = clear_done && (!hold_valid_r || q_push);
  assign accept   = in_valid && in_ready;

  // Holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (accept) begin
      hold_valid_r <= 1'b1;
    end else if (q_push) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_op_r <= in_op;
    end
  end

  // Slot index
  generate
    if (POW2) begin : g_mask
      // Power of two table: the low key bits are the index
      assign idx       = hold_op_r.key[IDX_W-1:0];
      assign idx_ready = 1'b1;
    end else begin : g_fold
      // Other sizes: fold the key in MSB first, a few bits a cycle, keeping
      // the running remainder below the entry count.
      localparam int unsigned RW     = IDX_W + 1;
      localparam int unsigned DIGITS = ttps_pkg::KEY_W / ttps_pkg::MOD_STEP;
      localparam int unsigned CNT_W  = $clog2(DIGITS);

      logic [RW-1:0]             rem_r;
      logic [RW-1:0]             rem_nxt;
      logic [ttps_pkg::KEY_W-1:0] key_sh_r;
      logic [CNT_W-1:0]          cnt_r;
      logic                      busy_r;

      always_comb begin
        rem_nxt = rem_r;
        for (int i = 0; i < int'(ttps_pkg::MOD_STEP); i++) begin
          rem_nxt = {rem_nxt[IDX_W-1:0], key_sh_r[ttps_pkg::KEY_W-1-i]};
          if (rem_nxt >= RW'(ENTRIES)) begin
            rem_nxt = rem_nxt - RW'(ENTRIES);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
        end else if (accept) begin
          busy_r <= 1'b1;
        end else if (busy_r && cnt_r == CNT_W'(DIGITS - 1)) begin
          busy_r <= 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (accept) begin
          rem_r    <= '0;
          key_sh_r <= in_op.key;
          cnt_r    <= '0;
        end else if (busy_r) begin
          rem_r    <= rem_nxt;
          key_sh_r <= key_sh_r << ttps_pkg::MOD_STEP;
          cnt_r    <= cnt_r + 1'b1;
        end
      end

      assign idx       = rem_r[IDX_W-1:0];
      assign idx_ready = !busy_r;
    end
  endgenerate

  // A store carries its score already in stored form
  always_comb begin
    q_op = hold_op_r;
    if (hold_op_r.func == ttps_pkg::FUNC_STORE) begin
      q_op.score = ttps_pkg::mate_adjust(hold_op_r.score, hold_op_r.ply,
                                         cfg.mate_threshold, 1'b1);
    end
  end

  assign q_data = {idx, q_op};

endmodule

`default_nettype wire

>>> rtl/ttps_back.sv
// ----------------------------------------------------------------------------
// ttps_back: table access and probe evaluation
// Clears the table after reset, writes stores, reads the slot of each probe
// and evaluates hit, depth and bound rules into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_back #(
  parameter int unsigned ENTRIES = ttps_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W  = $clog2(ENTRIES),
  localparam int unsigned QW     = $bits(ttps_pkg::op_t) + IDX_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ttps_pkg::cfg_t    cfg,
  input  wire logic              q_empty,
  output      logic              q_pop,
  input  wire logic [QW-1:0]     q_data,
  output      logic              clear_done,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      ttps_pkg::result_t out_res
);

  localparam int unsigned SW = $bits(ttps_pkg::slot_t);

  ttps_pkg::back_state_t state_r;
  ttps_pkg::back_state_t state_nxt;
  logic [IDX_W-1:0]      clr_cnt_r;
  logic [IDX_W-1:0]      clr_cnt_nxt;
  ttps_pkg::op_t         op_r;
  logic                  out_valid_r;
  ttps_pkg::result_t     out_res_r;
  logic                  load_out;

  ttps_pkg::op_t         head_op;
  logic [IDX_W-1:0]      head_idx;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  ttps_pkg::slot_t       ram_wdata;
  logic                  ram_re;
  logic [SW-1:0]         ram_rdata;
  ttps_pkg::slot_t       rd_slot;

  ttps_pkg::result_t     res;
  logic                  hit;
  logic                  depth_ok;
  logic                  bound_ok;
  logic signed [ttps_pkg::SCORE_W-1:0] adj_score;

  assign head_op  = q_data[$bits(ttps_pkg::op_t)-1:0];
  assign head_idx = q_data[QW-1:$bits(ttps_pkg::op_t)];
  assign rd_slot  = ram_rdata;

  // Slot storage
  ttps_ram #(
    .WIDTH (SW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_idx),
    .rdata (ram_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ttps_pkg::B_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Next state and table control
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = head_idx;
    ram_wdata.key   = head_op.key;
    ram_wdata.score = head_op.score;
    ram_wdata.kind  = head_op.kind;
    ram_wdata.depth = head_op.need_depth;
    ram_wdata.move  = head_op.move;
    ram_re      = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      ttps_pkg::B_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = ttps_pkg::B_IDLE;
        end
      end
      ttps_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (head_op.func == ttps_pkg::FUNC_STORE) begin
            ram_we = cfg.enable;
          end else begin
            ram_re    = 1'b1;
            state_nxt = ttps_pkg::B_EVAL;
          end
        end
      end
      ttps_pkg::B_EVAL: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ttps_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = ttps_pkg::B_IDLE;
      end
    endcase
  end

  // The popped item stays for evaluation
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= head_op;
    end
  end

  // Probe evaluation against the slot just read
  always_comb begin
    hit       = cfg.enable && (rd_slot.key == op_r.key);
    depth_ok  = (rd_slot.depth >= op_r.need_depth);
    adj_score = ttps_pkg::mate_adjust(rd_slot.score, op_r.ply,
                                      cfg.mate_threshold, 1'b0);
    case (rd_slot.kind)
      ttps_pkg::KIND_EXACT: bound_ok = 1'b1;
      ttps_pkg::KIND_UPPER: bound_ok = (adj_score <= op_r.alpha);
      ttps_pkg::KIND_LOWER: bound_ok = (adj_score >= op_r.beta);
      default:              bound_ok = 1'b0;
    endcase
    res.score_valid = hit && depth_ok && bound_ok;
    res.score_out   = res.score_valid ? adj_score : '0;
    res.key_hit     = hit;
    res.move_out    = hit ? rd_slot.move : '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_res    = out_res_r;
  assign clear_done = (state_r != ttps_pkg::B_CLEAR);

endmodule

`default_nettype wire

>>> rtl/transposition_table_probe_store.sv
// ----------------------------------------------------------------------------
// transposition_table_probe_store: direct-mapped search result table
// Probes and stores of search results in a table indexed by key modulo the
// entry count, with mate score ply adjustment on both paths.
//
//  Channel  Direction  Moves                      Accepted when
//  in_      sink       one probe or store item    in_tvalid & in_tready
//  out_     source     one result item per probe  out_tvalid & out_tready
//  cfg_     sink       one register write         cfg_valid & cfg_ready
//
// A power of two table takes a store every cycle while no stalled result holds
// the back part; a probe keeps the back part until its slot, read from the
// registered slot memory, is evaluated. Other sizes first reduce the key, four
// key bits a cycle, and the front takes no new item meanwhile. out_tvalid for
// a probe rises, at the soonest, once it has passed the holding register, the
// queue, the slot read and the output register. After reset a clearing pass
// zeroes every slot, in_tready low; configuration writes are taken throughout.
// A stalled output holds one result while the queue keeps taking items.
// ----------------------------------------------------------------------------
`default_nettype none

module transposition_table_probe_store #(
  parameter int unsigned ENTRIES = ttps_pkg::ENTRIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // tdata: key, need_depth, ply, alpha, beta, score_in, bound_kind, move_in
  input  wire logic [ttps_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: func
  input  wire logic                                in_tuser,
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  // tdata: score_valid, score_out, key_hit, move_out
  output      logic [ttps_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [ttps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ttps_pkg::THR_W-1:0]          cfg_data
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned QW    = $bits(ttps_pkg::op_t) + IDX_W;

  logic                        enable_r;
  logic [ttps_pkg::THR_W-1:0]  mate_thr_r;
  ttps_pkg::cfg_t              cfg;
  ttps_pkg::op_t               in_op;
  ttps_pkg::result_t           out_res;
  logic                        clear_done;
  logic                        q_push;
  logic [QW-1:0]               q_push_data;
  logic                        q_full;
  logic                        q_pop;
  logic [QW-1:0]               q_pop_data;
  logic                        q_empty;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= ttps_pkg::ENABLE_RST;
      mate_thr_r <= ttps_pkg::MATE_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ttps_pkg::CFG_ENABLE:   enable_r   <= cfg_data[0];
        ttps_pkg::CFG_MATE_THR: mate_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.enable         = enable_r;
  assign cfg.mate_threshold = mate_thr_r;

  // Input item unpacking
  assign in_op.func       = in_tuser;
  assign in_op.key        = in_tdata[63:0];
  assign in_op.need_depth = in_tdata[71:64];
  assign in_op.ply        = in_tdata[79:72];
  assign in_op.alpha      = in_tdata[103:80];
  assign in_op.beta       = in_tdata[127:104];
  assign in_op.score      = in_tdata[151:128];
  assign in_op.kind       = in_tdata[153:152];
  assign in_op.move       = in_tdata[185:154];

  // Front part
  ttps_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_op),
    .cfg        (cfg),
    .clear_done (clear_done),
    .q_push     (q_push),
    .q_data     (q_push_data),
    .q_full     (q_full)
  );

  // Queue between front and back
  ttps_fifo #(
    .WIDTH (QW),
    .DEPTH (ttps_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Back part
  ttps_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_pop_data),
    .clear_done (clear_done),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  // Result item packing, padded to whole bytes
  assign out_tdata = {
    (ttps_pkg::OUT_TDATA_W - $bits(ttps_pkg::result_t))'(0),
    out_res
  };

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Transposition table probe and store testbench
// Sends probe and store items into the table and keeps a mirror of the slots
// and registers in the bench. Every probe result is predicted from the mirror
// and compared field by field, across several enable and mate threshold
// settings, with random idling on both streams and long stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SLOTS     = ttps_pkg::ENTRIES_DEF;
  localparam int          SCORE_HI  = 8388607;
  localparam int          SCORE_LO  = -8388608;
  localparam int          CYCLE_CAP = 1000000;
  localparam int          SETTLE    = 32;
  localparam int          HOLD_LEN  = 400;

  // Bound kind without a meaning of its own; stored but never usable
  localparam logic [ttps_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic [ttps_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [ttps_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [ttps_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [ttps_pkg::THR_W-1:0]       cfg_data = '0;

  // Mirror of the table slots and registers
  logic [ttps_pkg::KEY_W-1:0]   mirror_key   [SLOTS];
  int                           mirror_score [SLOTS];
  logic [ttps_pkg::KIND_W-1:0]  mirror_kind  [SLOTS];
  logic [ttps_pkg::DEPTH_W-1:0] mirror_depth [SLOTS];
  logic [ttps_pkg::MOVE_W-1:0]  mirror_move  [SLOTS];
  bit                           enable_now = 1'b1;
  int                           thr_now = int'(ttps_pkg::MATE_THR_RST);

  // Items waiting to be sent and probe answers waiting to arrive
  ttps_pkg::op_t     op_queue[$];
  ttps_pkg::result_t probe_answers[$];

  logic [ttps_pkg::KEY_W-1:0] key_pool[32];
  ttps_pkg::op_t              tx_item = '0;
  bit                         tx_busy = 1'b0;
  int                         tx_gap = 0;
  int                         rx_gap = 0;
  int                         mismatches = 0;
  int                         cycle_cnt = 0;
  bit                         calm = 1'b0;
  int                         hold_req = 0;
  int                         hold_seen = 0;
  int                         hold_cnt = 0;

  transposition_table_probe_store u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      mirror_key[i]   = '0;
      mirror_score[i] = 0;
      mirror_kind[i]  = ttps_pkg::KIND_EXACT;
      mirror_depth[i] = '0;
      mirror_move[i]  = '0;
    end
  end

  // Grow (store) or shrink (probe) a mate score by the ply count, reapplying
  // the original sign (a shrink may cross zero), then saturate to score range.
  function automatic int mate_ply_shift(input int s, input int plies, input bit grow);
    int mag;
    int m;
    mag = (s < 0) ? -s : s;
    if (mag < thr_now) return s;
    m = grow ? mag + plies : mag - plies;
    m = (s < 0) ? -m : m;
    if (m > SCORE_HI) m = SCORE_HI;
    if (m < SCORE_LO) m = SCORE_LO;
    return m;
  endfunction

  // Apply one accepted item to the mirror; a probe queues its answer.
  task automatic probe_or_store(input ttps_pkg::op_t it);
    int unsigned       slot;
    int                s;
    bit                usable;
    ttps_pkg::result_t ans;
    slot = 32'(it.key % 64'(SLOTS));
    if (it.func == ttps_pkg::FUNC_STORE) begin
      if (enable_now) begin
        mirror_key[slot]   = it.key;
        mirror_score[slot] = mate_ply_shift(int'($signed(it.score)), int'(it.ply), 1'b1);
        mirror_kind[slot]  = it.kind;
        mirror_depth[slot] = it.need_depth;
        mirror_move[slot]  = it.move;
      end
    end else begin
      ans = '0;
      if (enable_now && mirror_key[slot] == it.key) begin
        ans.key_hit  = 1'b1;
        ans.move_out = mirror_move[slot];
        if (mirror_depth[slot] >= it.need_depth) begin
          s = mate_ply_shift(mirror_score[slot], int'(it.ply), 1'b0);
          usable = (mirror_kind[slot] == ttps_pkg::KIND_EXACT) ||
                   (mirror_kind[slot] == ttps_pkg::KIND_UPPER &&
                    s <= int'($signed(it.alpha))) ||
                   (mirror_kind[slot] == ttps_pkg::KIND_LOWER &&
                    s >= int'($signed(it.beta)));
          if (usable) begin
            ans.score_valid = 1'b1;
            ans.score_out   = s[ttps_pkg::SCORE_W-1:0];
          end
        end
      end
      probe_answers.push_back(ans);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Idle length: mostly none or short, a few long.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Score picker biased towards small values, the mate threshold region and
  // the range extremes.
  function automatic logic [ttps_pkg::SCORE_W-1:0] pick_score();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      v = int'($urandom_range(0, 4000)) - 2000;
    end else if (r < 65) begin
      v = thr_now + int'($urandom_range(0, 600)) - 300;
      if ($urandom_range(0, 1) == 1) v = -v;
    end else if (r < 85) begin
      return ttps_pkg::SCORE_W'($urandom);
    end else begin
      case ($urandom_range(0, 4))
        0:       v = SCORE_HI;
        1:       v = SCORE_LO;
        2:       v = 0;
        3:       v = thr_now;
        default: v = -thr_now;
      endcase
    end
    if (v > SCORE_HI) v = SCORE_HI;
    if (v < SCORE_LO) v = SCORE_LO;
    return v[ttps_pkg::SCORE_W-1:0];
  endfunction

  function automatic ttps_pkg::op_t make_op(
    input logic                        func,
    input logic [ttps_pkg::KEY_W-1:0]  key,
    input int                          depth,
    input int                          plies,
    input int                          a,
    input int                          b,
    input int                          s,
    input logic [ttps_pkg::KIND_W-1:0] kind,
    input logic [ttps_pkg::MOVE_W-1:0] mv
  );
    ttps_pkg::op_t it;
    it.func       = func;
    it.key        = key;
    it.need_depth = ttps_pkg::DEPTH_W'(depth);
    it.ply        = ttps_pkg::PLY_W'(plies);
    it.alpha      = ttps_pkg::SCORE_W'(a);
    it.beta       = ttps_pkg::SCORE_W'(b);
    it.score      = ttps_pkg::SCORE_W'(s);
    it.kind       = kind;
    it.move       = mv;
    return it;
  endfunction

  // Random item: mostly keys from a small pool so that stores are found
  // again, the rest fully random keys.
  function automatic ttps_pkg::op_t random_op();
    ttps_pkg::op_t it;
    int            r;
    it.func = ($urandom_range(0, 99) < 45) ? ttps_pkg::FUNC_STORE : ttps_pkg::FUNC_PROBE;
    if ($urandom_range(0, 99) < 20) it.key = {$urandom, $urandom};
    else it.key = key_pool[$urandom_range(0, 31)];
    it.need_depth = ($urandom_range(0, 99) < 70) ?
                    ttps_pkg::DEPTH_W'($urandom_range(0, 12)) :
                    ttps_pkg::DEPTH_W'($urandom);
    it.ply   = ($urandom_range(0, 99) < 50) ? ttps_pkg::PLY_W'($urandom_range(0, 8)) :
                                              ttps_pkg::PLY_W'($urandom);
    it.alpha = pick_score();
    it.beta  = pick_score();
    it.score = pick_score();
    r = $urandom_range(0, 99);
    if (r < 30) it.kind = ttps_pkg::KIND_EXACT;
    else if (r < 60) it.kind = ttps_pkg::KIND_UPPER;
    else if (r < 92) it.kind = ttps_pkg::KIND_LOWER;
    else it.kind = KIND_SPARE;
    it.move = $urandom;
    return it;
  endfunction

  task automatic queue_random(input int count);
    repeat (count) op_queue.push_back(random_op());
  endtask

  // Wait until every item is sent and every answer has come, then let any
  // store still in flight settle.
  task automatic drain();
    do @(posedge clk);
    while (op_queue.size() != 0 || tx_busy || probe_answers.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ttps_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ttps_pkg::THR_W'(value);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ttps_pkg::CFG_ENABLE:   enable_now = value[0];
      ttps_pkg::CFG_MATE_THR: thr_now = value & 32'h7F_FFFF;
      default: ;
    endcase
  endtask

  // Sender: one item at a time from the pending queue, with random gaps.
  always @(posedge clk) begin : sender
    bit offering;
    if (rst_n) begin
      offering = in_tvalid;
      if (in_tvalid && in_tready) begin
        probe_or_store(tx_item);
        offering = 1'b0;
        tx_gap = idle_len();
      end
      if (!offering) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (op_queue.size() != 0) begin
          tx_item = op_queue.pop_front();
          offering = 1'b1;
        end
      end
      tx_busy = offering;
      in_tvalid <= offering;
      in_tuser  <= tx_item.func;
      in_tdata  <= {6'd0, tx_item.move, tx_item.kind, tx_item.score, tx_item.beta,
                    tx_item.alpha, tx_item.ply, tx_item.need_depth, tx_item.key};
    end
  end

  // Long receiver hold-off, counted here on request from the stimulus.
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_cnt  <= HOLD_LEN;
    end
  end

  // Receiver: check each result item against the oldest answer.
  always @(posedge clk) begin : receiver
    ttps_pkg::result_t got;
    ttps_pkg::result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = ttps_pkg::result_t'(out_tdata[$bits(ttps_pkg::result_t)-1:0]);
        if (probe_answers.size() == 0) begin
          report_mismatch("result item with no probe outstanding");
        end else begin
          want = probe_answers.pop_front();
          if (got.score_valid !== want.score_valid)
            report_mismatch($sformatf("score_valid %b, want %b",
                                      got.score_valid, want.score_valid));
          if (got.score_out !== want.score_out)
            report_mismatch($sformatf("score_out %0d, want %0d",
                                      got.score_out, want.score_out));
          if (got.key_hit !== want.key_hit)
            report_mismatch($sformatf("key_hit %b, want %b", got.key_hit, want.key_hit));
          if (got.move_out !== want.move_out)
            report_mismatch($sformatf("move_out %h, want %h", got.move_out, want.move_out));
        end
        rx_gap = idle_len();
      end
      if (hold_cnt != 0) begin
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ttps_pkg::KEY_W-1:0] k_ones;
    logic [ttps_pkg::KEY_W-1:0] k_alias;
    logic [ttps_pkg::KEY_W-1:0] k_low;
    logic [ttps_pkg::KEY_W-1:0] k_mid;
    logic [ttps_pkg::KEY_W-1:0] k_odd;
    k_ones  = '1;
    k_alias = 64'h0123_4567_89AB_CFFF;
    k_low   = 64'h8000_0000_0000_0123;
    k_mid   = 64'h0000_0000_0000_0555;
    k_odd   = 64'h5A5A_5A5A_5A5A_5A5A;

    // Key pool: zero, an alias of slot zero, all ones, and a few keys
    // sharing a slot with another pool key.
    for (int i = 0; i < 32; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 24; i < 32; i++) key_pool[i][11:0] = key_pool[i - 24][11:0];
    key_pool[0] = '0;
    key_pool[1] = {$urandom, 20'h0_0000, 12'h000} | 64'h1000;
    key_pool[2] = '1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: key zero on the cleared table, range extremes with mate
    // saturation, window checks for each bound kind, bound kind three,
    // insufficient depth and a slot taken over by another key.
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, '0, 0, 0, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, '0, 1, 0, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, 64'h1000, 0, 0, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_STORE, k_ones, 255, 255, 0, 0, SCORE_HI,
                               ttps_pkg::KIND_EXACT, '1));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_ones, 255, 0, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_ones, 255, 255, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_STORE, k_low, 10, 255, 0, 0, SCORE_LO,
                               ttps_pkg::KIND_LOWER, 32'h1));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_low, 10, 0, SCORE_HI, SCORE_LO, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_low, 10, 0, SCORE_LO, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_STORE, k_mid, 3, 7, 0, 0, 500,
                               ttps_pkg::KIND_UPPER, 32'hCAFE));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_mid, 3, 7, 500, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_mid, 3, 7, 499, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_mid, 4, 7, 500, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_STORE, k_odd, 5, 0, 0, 0, 42,
                               KIND_SPARE, 32'h8000_0001));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_odd, 0, 0, SCORE_HI, SCORE_LO, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_STORE, k_alias, 1, 0, 0, 0, -77,
                               ttps_pkg::KIND_EXACT, 32'h55));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_ones, 0, 0, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_alias, 1, 0, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_STORE, k_odd, 2, 20, 0, 0, -100000,
                               ttps_pkg::KIND_EXACT, 32'h7));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_odd, 2, 20, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_STORE, k_mid, 2, 50, 0, 0, 99999,
                               ttps_pkg::KIND_EXACT, 32'h9));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_mid, 2, 50, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    drain();

    // Random traffic at reset settings, opening with a long receiver stall
    hold_req <= hold_req + 1;
    queue_random(150);
    drain();

    // Threshold zero: every score is a mate score, and a probe may push a
    // small score across zero in either direction.
    write_reg(ttps_pkg::CFG_MATE_THR, 0);
    op_queue.push_back(make_op(ttps_pkg::FUNC_STORE, k_mid, 0, 10, 0, 0, 5,
                               ttps_pkg::KIND_EXACT, 32'h11));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_mid, 0, 20, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_STORE, k_low, 0, 3, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, 32'h22));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_low, 0, 7, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    op_queue.push_back(make_op(ttps_pkg::FUNC_STORE, k_odd, 0, 0, 0, 0, -3,
                               ttps_pkg::KIND_EXACT, 32'h33));
    op_queue.push_back(make_op(ttps_pkg::FUNC_PROBE, k_odd, 0, 9, 0, 0, 0,
                               ttps_pkg::KIND_EXACT, '0));
    queue_random(150);
    drain();

    // Largest threshold, no idling on either side
    write_reg(ttps_pkg::CFG_MATE_THR, 8388607);
    calm <= 1'b1;
    queue_random(120);
    drain();
    calm <= 1'b0;

    // Table disabled: probes miss, stores change nothing
    write_reg(ttps_pkg::CFG_ENABLE, 0);
    queue_random(80);
    drain();

    // Small threshold, enabled again, with another long receiver stall
    write_reg(ttps_pkg::CFG_MATE_THR, 200);
    write_reg(ttps_pkg::CFG_ENABLE, 1);
    hold_req <= hold_req + 1;
    queue_random(150);
    drain();

    write_reg(ttps_pkg::CFG_MATE_THR, 100000);
    queue_random(100);
    drain();

    if (mismatches == 0 && probe_answers.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
